### sv/distance_to_time_curve_matcher_defines.svh
// assertion macros shared by the checker
`ifndef DISTANCE_TO_TIME_CURVE_MATCHER_DEFINES_SVH
`define DISTANCE_TO_TIME_CURVE_MATCHER_DEFINES_SVH

// property that holds in the cycle after a condition
`define DTCM_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("dtcm check failed");

// property that holds in the same cycle
`define DTCM_ASSERT_NOW(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("dtcm check failed");

`endif

### sv/dtcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dtcm_pkg;
	localparam int MaxKeysDefault = 64;

	localparam logic [2:0] RegKeyCount  = 3'd0;
	localparam logic [2:0] RegUpperUniq = 3'd1;
	localparam logic [2:0] RegLowerUniq = 3'd2;
	localparam logic [2:0] RegCacheEn   = 3'd3;
	localparam logic [2:0] RegLimitEn   = 3'd4;
	localparam logic [2:0] RegDistLimit = 3'd5;
	localparam logic [2:0] RegPlayLen   = 3'd6;
	localparam logic [2:0] RegRateScale = 3'd7;

	localparam logic CmdLoad  = 1'b0;
	localparam logic CmdFrame = 1'b1;

	// divider control handed to the divide unit
	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SETUP, ST_RD_FIRST, ST_CHK_FIRST, ST_RD_LAST, ST_CHK_LAST,
		ST_RD_CACHE, ST_CHK_CACHE, ST_BS_RD, ST_BS_RD2, ST_BS_CHK,
		ST_LB_RD, ST_LB_CHK, ST_IP_RD0, ST_IP_RD1, ST_IP_DIV, ST_IP_WAIT,
		ST_IP_MUL, ST_IP_MUL2, ST_IP_ADD, ST_RD_TIME, ST_GOT_TIME, ST_ACC, ST_OUT
	} state_t;
endpackage
`default_nettype wire

### sv/dtcm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle, unsigned 48 by 32
module dtcm_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dtcm_pkg::div_req_t  req,
	output logic                     busy,
	output logic [47:0]              quo
);
	import dtcm_pkg::*;

	logic [5:0]  cnt_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[47]};
	assign trial   = shifted - {1'b0, den_q};
	assign busy    = (cnt_q != 6'd0);
	assign quo     = quo_q;

	// one shift and subtract per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### sv/distance_to_time_curve_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// a load result is valid in the cycle after its input transfer; a frame result waits on
// the key search steps and, when interpolating, on the serial divider and the multiply
// and add steps; one item at a time, the next input transfer comes the cycle after the
// result transfer; reset: arst_n clears control, cache index, accumulator and config
// registers; key memory contents are undefined until loaded
module distance_to_time_curve_matcher #(
	parameter int MAX_KEYS = dtcm_pkg::MaxKeysDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [5:0]  key_index,
	input  wire logic [31:0] key_time,
	input  wire logic signed [31:0] key_value,
	input  wire logic signed [31:0] distance,
	input  wire logic [15:0] delta_time,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      play_time,
	output logic [5:0]       matched_key,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import dtcm_pkg::*;

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);

	// config registers
	logic [6:0]  key_count_q;
	logic        ub_uniq_q, lb_uniq_q, cache_en_q, limit_en_q;
	logic signed [31:0] dist_limit_q;
	logic [31:0] play_len_q;
	logic signed [15:0] rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= '0;
			ub_uniq_q    <= 1'b1;
			lb_uniq_q    <= 1'b1;
			cache_en_q   <= 1'b1;
			limit_en_q   <= 1'b0;
			dist_limit_q <= '0;
			play_len_q   <= '0;
			rate_q       <= 16'sd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegKeyCount:  key_count_q  <= cfg_data[6:0];
				RegUpperUniq: ub_uniq_q    <= cfg_data[0];
				RegLowerUniq: lb_uniq_q    <= cfg_data[0];
				RegCacheEn:   cache_en_q   <= cfg_data[0];
				RegLimitEn:   limit_en_q   <= cfg_data[0];
				RegDistLimit: dist_limit_q <= cfg_data;
				RegPlayLen:   play_len_q   <= cfg_data;
				RegRateScale: rate_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// key memories, registered read
	logic [31:0] tmem [MAX_KEYS];
	logic [31:0] vmem [MAX_KEYS];
	logic [AW-1:0] raddr;
	logic [31:0] rd_t_q;
	logic signed [31:0] rd_v_q;
	logic wr_en;

	assign wr_en = in_valid && !in_stall && (command == CmdLoad)
		&& ({26'd0, key_index} < 32'(MAX_KEYS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tmem[AW'(key_index)] <= key_time;
			vmem[AW'(key_index)] <= key_value;
		end
		rd_t_q <= tmem[raddr];
		rd_v_q <= vmem[raddr];
	end

	// sequencer state
	state_t st_q, st_d;
	logic signed [31:0] dist_q;
	logic [15:0] dt_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] last_q, c_q, cache_q;
	logic signed [AW+1:0] lo_q, hi_q, mid_q;
	logic [AW:0] first_q, cnt_q;
	logic signed [31:0] v0_q, vprev_q;
	logic [31:0] t0_q;
	logic signed [33:0] vspan;
	logic signed [34:0] dt_diff_q;
	logic signed [63:0] ctime_q;
	logic [31:0] acc_q;
	logic neg_q;
	logic [47:0] alpha_q;
	logic [95:0] prod_q;
	logic hold_q;

	div_req_t dreq;
	logic dbusy;
	logic [47:0] dquo;

	dtcm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quo(dquo));

	// next state
	logic signed [AW+1:0] bs_mid;
	logic [AW:0] lb_mid, lb_step;
	assign bs_mid  = lo_q + ((hi_q - lo_q) >>> 1);
	assign lb_step = cnt_q >> 1;
	assign lb_mid  = first_q + lb_step;

	// value span of the bracketing keys, valid while the upper key is read back
	assign vspan = 34'(rd_v_q) - 34'(v0_q);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_valid) st_d = (command == CmdFrame) ? ST_SETUP : ST_OUT;
			ST_SETUP: begin
				if (hold_q && acc_q != 0) st_d = ST_ACC;
				else if (n_q == 0) st_d = ST_ACC;
				else st_d = ST_RD_FIRST;
			end
			ST_RD_FIRST:  st_d = ST_CHK_FIRST;
			ST_CHK_FIRST: begin
				if (n_q == 1 || (!lb_uniq_q && dist_q == rd_v_q)) st_d = ST_GOT_TIME;
				else st_d = ST_RD_LAST;
			end
			ST_RD_LAST:  st_d = ST_CHK_LAST;
			ST_CHK_LAST: begin
				if (dist_q >= rd_v_q) begin
					if (ub_uniq_q) st_d = ST_RD_TIME;
					else if (cache_en_q) st_d = ST_RD_CACHE;
					else st_d = ST_BS_RD;
				end else st_d = ST_LB_RD;
			end
			ST_RD_CACHE:  st_d = ST_CHK_CACHE;
			ST_CHK_CACHE: st_d = (dist_q == rd_v_q) ? ST_GOT_TIME : ST_BS_RD;
			ST_BS_RD:  st_d = (lo_q <= hi_q) ? ST_BS_RD2 : ST_RD_TIME;
			ST_BS_RD2: st_d = ST_BS_CHK;
			ST_BS_CHK: begin
				if ((mid_q == 0 || vprev_q < dist_q) && rd_v_q == dist_q) st_d = ST_GOT_TIME;
				else st_d = ST_BS_RD;
			end
			ST_LB_RD:  st_d = (cnt_q > 0) ? ST_LB_CHK : ST_IP_RD0;
			ST_LB_CHK: st_d = ST_LB_RD;
			ST_IP_RD0: st_d = ST_IP_RD1;
			ST_IP_RD1: st_d = ST_IP_DIV;
			ST_IP_DIV: st_d = (vspan <= 0) ? ST_ACC : ST_IP_WAIT;
			ST_IP_WAIT: if (!dbusy && !dreq.start) st_d = ST_IP_MUL;
			ST_IP_MUL: st_d = ST_IP_MUL2;
			ST_IP_MUL2: st_d = ST_IP_ADD;
			ST_IP_ADD: st_d = ST_ACC;
			ST_RD_TIME:  st_d = ST_GOT_TIME;
			ST_GOT_TIME: st_d = ST_ACC;
			ST_ACC: st_d = ST_OUT;
			ST_OUT: if (!out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign play_time = acc_q;
	assign matched_key = 6'(cache_q);

	always_comb begin
		raddr = '0;
		unique case (st_q)
			ST_RD_LAST: raddr = last_q;
			ST_RD_CACHE: raddr = c_q;
			ST_BS_RD:  raddr = (bs_mid > 0) ? AW'(bs_mid - 1) : '0;
			ST_BS_RD2: raddr = AW'(mid_q);
			ST_LB_RD:  raddr = AW'(lb_mid);
			ST_IP_RD0: raddr = AW'(first_q - 1);
			ST_IP_RD1: raddr = AW'(first_q);
			ST_RD_TIME: raddr = last_q;
			ST_CHK_CACHE: raddr = c_q;
			ST_BS_CHK: raddr = AW'(mid_q);
			default: raddr = '0;
		endcase
	end

	always_comb begin
		dreq.start = (st_q == ST_IP_DIV) && (vspan > 0);
		dreq.num   = alpha_q;
		dreq.den   = vspan[31:0];
	end

	// clamp helper
	function automatic logic [31:0] clampt(input logic signed [63:0] t, input logic [31:0] l);
		if (t < 0) return '0;
		if (t > $signed({32'd0, l})) return l;
		return t[31:0];
	endfunction

	logic signed [63:0] target;
	logic signed [31:0] radv;
	logic signed [63:0] sum;
	logic signed [31:0] p;
	assign target = $signed({32'd0, clampt(ctime_q, play_len_q)});
	assign p = $signed({16'd0, dt_q}) * rate_q;
	assign radv = (p < 0) ? -((-p) >>> 8) : (p >>> 8);
	assign sum = $signed({32'd0, acc_q}) + 64'(radv);

	logic [AW:0] c_cap;
	assign c_cap = ({1'b0, cache_q} > {1'b0, AW'(n_q - 1)}) ? {1'b0, AW'(n_q - 1)}
		: {1'b0, cache_q};

	// lower-bound search start, capped at the last key
	logic [AW:0] first_init;
	assign first_init = cache_en_q ? ((c_q >= last_q) ? {1'b0, last_q}
		: (AW+1)'(c_q) + 1'b1) : (last_q > 1 ? (AW+1)'(1) : {1'b0, last_q});

	// distance offset from the lower key, as sign and magnitude
	logic signed [33:0] voff;
	logic [33:0] voff_mag;
	assign voff     = 34'(dist_q) - 34'(rd_v_q);
	assign voff_mag = voff[33] ? 34'(-voff) : 34'(voff);

	// split multiply, 24 by 32 bits per cycle, and saturated product
	logic [31:0] dt_mag;
	logic [23:0] mul_a;
	logic [55:0] mul_p;
	logic [63:0] psat;
	assign dt_mag = dt_diff_q[34] ? 32'(-dt_diff_q) : dt_diff_q[31:0];
	assign mul_a  = (st_q == ST_IP_MUL) ? dquo[23:0] : dquo[47:24];
	assign mul_p  = mul_a * dt_mag;
	assign psat   = (prod_q[95:62] != '0) ? (64'd1 << 46) : 64'(prod_q[61:16]);

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			acc_q   <= '0;
			cache_q <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_IDLE: begin
					dist_q  <= distance;
					dt_q    <= delta_time;
					ctime_q <= '0;
					n_q     <= ({25'd0, key_count_q} > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
						: CW'(key_count_q);
					hold_q  <= limit_en_q && (distance >= dist_limit_q);
				end
				ST_RD_FIRST: begin
					last_q <= AW'(n_q - 1);
					c_q    <= AW'(c_cap);
				end
				ST_CHK_FIRST: ;
				ST_CHK_LAST: begin
					lo_q <= '0;
					hi_q <= (AW+2)'(last_q);
					first_q <= first_init;
				end
				ST_LB_RD: ;
				ST_BS_RD: begin
					mid_q <= bs_mid;
					if (lo_q > hi_q) cache_q <= last_q;
				end
				ST_BS_RD2: vprev_q <= rd_v_q;
				ST_BS_CHK: begin
					if ((mid_q == 0 || vprev_q < dist_q) && rd_v_q == dist_q)
						cache_q <= AW'(mid_q);
					else if (dist_q > rd_v_q) lo_q <= (AW+2)'(mid_q + 1);
					else hi_q <= (AW+2)'(mid_q - 1);
				end
				ST_LB_CHK: begin
					if (dist_q >= rd_v_q) begin
						first_q <= (AW+1)'(lb_mid + 1);
						cnt_q   <= (AW+1)'(cnt_q - lb_step - 1);
					end else cnt_q <= lb_step;
				end
				ST_IP_RD1: begin
					v0_q <= rd_v_q;
					t0_q <= rd_t_q;
					cache_q <= AW'(first_q - 1);
				end
				ST_IP_DIV: begin
					dt_diff_q <= 35'({1'b0, rd_t_q}) - 35'({1'b0, t0_q});
					ctime_q <= 64'({1'b0, t0_q});
				end
				ST_IP_MUL: prod_q <= 96'(mul_p);
				ST_IP_MUL2: prod_q <= prod_q + {16'd0, mul_p, 24'd0};
				ST_IP_ADD:
					ctime_q <= (neg_q ^ dt_diff_q[34]) ? 64'(t0_q) - psat
						: 64'(t0_q) + psat;
				ST_GOT_TIME: ctime_q <= 64'({1'b0, rd_t_q});
				ST_ACC: begin
					if (hold_q) begin
						if (acc_q == 0) acc_q <= target[31:0];
						else acc_q <= clampt($signed({32'd0, acc_q}), play_len_q);
					end else if (target > $signed({32'd0, acc_q})) acc_q <= target[31:0];
					else acc_q <= clampt(sum, play_len_q);
				end
				default: ;
			endcase
			// prepare lower-bound count and dividend
			if (st_q == ST_CHK_LAST && !(dist_q >= rd_v_q)) begin
				cnt_q <= {1'b0, last_q} - first_init;
			end
			if (st_q == ST_IP_RD1) begin
				alpha_q <= {voff_mag[31:0], 16'd0};
				neg_q   <= voff[33];
			end
		end
	end
endmodule
`default_nettype wire

### sv/dtcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "distance_to_time_curve_matcher_defines.svh"
module dtcm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [31:0] play_time
);
	// a stalled result holds
	`DTCM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(play_time))
	// no input taken while a result waits
	`DTCM_ASSERT_NOW(a_busy, out_valid, in_stall)
	// a taken item blocks the next cycle
	`DTCM_ASSERT_NEXT(a_seq, in_valid && !in_stall, in_stall)
endmodule
bind distance_to_time_curve_matcher dtcm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .play_time(play_time));
`default_nettype wire
